>>> design/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg - shared types, constants and tables of the PSK symbol decoder
// Holds field widths, register indexes, the sine table and the microprogram
// that sequences the shared multiplier datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

    // field widths
    localparam int PHASE_W  = 8;
    localparam int SYM_W    = 2;
    localparam int COUNT_W  = 23;
    localparam int SCALE_W  = 32;
    localparam int LEVEL_W  = 10;
    localparam int AVG_W    = 16;
    localparam int HIST_W   = 32;
    localparam int NCO_W    = 16;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 32;
    localparam int STEP_W   = 4;
    localparam int ACC_W    = 44;
    localparam int OPA_W    = 24;
    localparam int OPB_W    = 17;
    localparam int PROD_W   = OPA_W + OPB_W;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_QPSK_MODE      = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LOWER_SIDEBAND = 3'd1;
    localparam logic [CIDX_W-1:0] REG_AFC_ENABLE     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DETECT_LEVEL   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_TUNE_FREQ      = 3'd4;
    localparam logic [CIDX_W-1:0] REG_STEP_SCALE     = 3'd5;

    // reset values
    localparam logic [COUNT_W-1:0] TUNE_FREQ_RST  = 23'd2000000;
    localparam logic [SCALE_W-1:0] STEP_SCALE_RST = 32'd17592186;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 23'h7FFFFF;

    // history patterns
    localparam logic [HIST_W-1:0] HIST_PREAMBLE  = 32'hAAAAAAAA;
    localparam logic [HIST_W-1:0] HIST_POSTAMBLE = 32'h0;

    // leaky average coefficients, Q0.15
    localparam logic signed [OPB_W-1:0] K_NEW   = 17'sd1638;
    localparam logic signed [OPB_W-1:0] K_OLD   = 17'sd31130;
    localparam logic signed [ACC_W-1:0] K_ROUND = 44'sd16384;
    localparam logic signed [AVG_W-1:0] AVG_FULL = 16'sd32767;

    // quarter-wave sine, round(32767*sin(k*2pi/256)), k = 0..64
    localparam logic [AVG_W-1:0] SINE_TAB [0:64] = '{
        16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,
        16'd4808,  16'd5602,  16'd6393,  16'd7179,  16'd7962,  16'd8739,
        16'd9512,  16'd10278, 16'd11039, 16'd11793, 16'd12539, 16'd13279,
        16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
        16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403,
        16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279, 16'd24811,
        16'd25329, 16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683,
        16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
        16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580,
        16'd31785, 16'd31971, 16'd32137, 16'd32285, 16'd32412, 16'd32521,
        16'd32609, 16'd32678, 16'd32728, 16'd32757, 16'd32767
    };

    // full-turn sine from the quarter-wave table
    function automatic logic signed [AVG_W-1:0] rom_sin(input logic [PHASE_W-1:0] a);
        logic [6:0]       r;
        logic [AVG_W-1:0] v;
        r = {1'b0, a[5:0]};
        case (a[7:6])
            2'd0:    v = SINE_TAB[r];
            2'd1:    v = SINE_TAB[7'd64 - r];
            2'd2:    v = AVG_W'(16'd0 - SINE_TAB[r]);
            default: v = AVG_W'(16'd0 - SINE_TAB[7'd64 - r]);
        endcase
        return signed'(v);
    endfunction

    // sequencer branch conditions
    typedef enum logic [1:0] {
        C_NEXT = 2'd0,   // advance
        C_IN   = 2'd1,   // hold until an item is accepted, then advance
        C_OUT  = 2'd2    // hold until the result slot is free, then jump
    } t_cond;

    // multiplier operand selects
    typedef enum logic [1:0] {
        A_TRIG = 2'd0,
        A_AVGI = 2'd1,
        A_AVGQ = 2'd2,
        A_CNT  = 2'd3
    } t_asel;

    typedef enum logic [2:0] {
        B_KNEW = 3'd0,
        B_KOLD = 3'd1,
        B_AVGI = 3'd2,
        B_AVGQ = 3'd3,
        B_SCLO = 3'd4,
        B_SCHI = 3'd5
    } t_bsel;

    // accumulator operations
    typedef enum logic [2:0] {
        ACC_HOLD  = 3'd0,
        ACC_LOAD  = 3'd1,
        ACC_LDRND = 3'd2,
        ACC_ADD   = 3'd3,
        ACC_SHADD = 3'd4
    } t_accop;

    typedef struct packed {
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              use_sin;   // trig operand is sine, else cosine
        t_asel             a_sel;
        t_bsel             b_sel;
        t_accop            acc_op;
        logic              wr_avg_i;
        logic              wr_avg_q;  // also applies preamble/postamble
        logic              chk_level;
        logic              emit;
    } t_ctrl;

    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;

    // microprogram
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '{cond: C_NEXT, target: STEP_FIRST, use_sin: 1'b0, a_sel: A_TRIG,
              b_sel: B_KNEW, acc_op: ACC_HOLD, wr_avg_i: 1'b0, wr_avg_q: 1'b0,
              chk_level: 1'b0, emit: 1'b0};
        case (step)
            4'd0:  c.cond = C_IN;
            4'd1:  c.acc_op = ACC_LDRND;
            4'd2:  begin
                c.a_sel = A_AVGI; c.b_sel = B_KOLD; c.acc_op = ACC_ADD;
            end
            4'd3:  begin
                c.wr_avg_i = 1'b1; c.use_sin = 1'b1; c.acc_op = ACC_LDRND;
            end
            4'd4:  begin
                c.a_sel = A_AVGQ; c.b_sel = B_KOLD; c.acc_op = ACC_ADD;
            end
            4'd5:  c.wr_avg_q = 1'b1;
            4'd6:  begin
                c.a_sel = A_AVGI; c.b_sel = B_AVGI; c.acc_op = ACC_LOAD;
            end
            4'd7:  begin
                c.a_sel = A_AVGQ; c.b_sel = B_AVGQ; c.acc_op = ACC_ADD;
            end
            4'd8:  begin
                c.chk_level = 1'b1; c.a_sel = A_CNT; c.b_sel = B_SCLO;
                c.acc_op = ACC_LOAD;
            end
            4'd9:  begin
                c.a_sel = A_CNT; c.b_sel = B_SCHI; c.acc_op = ACC_SHADD;
            end
            4'd10: begin
                c.emit = 1'b1; c.cond = C_OUT; c.target = STEP_FIRST;
            end
            default: begin
                c.cond = C_OUT; c.target = STEP_FIRST;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/psd_in_if.sv
// ----------------------------------------------------------------------------
// psd_in_if - symbol phase channel
// Valid/ready channel carrying one carrier phase item per symbol.
// ----------------------------------------------------------------------------
`default_nettype none

interface psd_in_if import psd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] symbol_phase;

    modport source (output valid, output symbol_phase, input ready);
    modport sink   (input valid, input symbol_phase, output ready);
endinterface

`default_nettype wire

>>> design/psd_res_if.sv
// ----------------------------------------------------------------------------
// psd_res_if - decoded symbol channel
// Valid/ready channel carrying symbol, carrier detect, delta and NCO step.
// ----------------------------------------------------------------------------
`default_nettype none

interface psd_res_if import psd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SYM_W-1:0]   symbol;
    logic               carrier_detect;
    logic [PHASE_W-1:0] phase_delta;
    logic [NCO_W-1:0]   nco_step;

    modport source (output valid, output symbol, output carrier_detect,
                    output phase_delta, output nco_step, input ready);
    modport sink   (input valid, input symbol, input carrier_detect,
                    input phase_delta, input nco_step, output ready);
endinterface

`default_nettype wire

>>> design/psd_cfg_if.sv
// ----------------------------------------------------------------------------
// psd_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface psd_cfg_if import psd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/psk_symbol_dcd_afc.sv
// ----------------------------------------------------------------------------
// psk_symbol_dcd_afc - PSK symbol decision with carrier detect and AFC
// Differential phase decision, leaky cos/sin average and history based
// carrier detect, and carrier count correction scaled to an NCO step. A
// microcoded sequencer drives one shared 24x17 multiplier and accumulator.
// ----------------------------------------------------------------------------
// Sequence: the item is accepted in step 0 and the result is registered in the
//   emit step, step 10, once the result slot is free. A new item is taken only
//   after the eleven-step microprogram sharing one multiplier has finished the last.
// Reset: synchronous, active low; control and state registers return to their
//   reset values and the carrier count is loaded with the tune frequency reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module psk_symbol_dcd_afc import psd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    psd_cfg_if.sink   i_cfg,
    psd_in_if.sink    i_sym,
    psd_res_if.source o_res
);

    // configuration
    logic               r_qpsk, r_lsb, r_afc_en;
    logic [LEVEL_W-1:0] r_level;
    logic [SCALE_W-1:0] r_scale;

    // state
    logic [STEP_W-1:0]       r_step, n_step;
    logic [PHASE_W-1:0]      r_prev;
    logic [HIST_W-1:0]       r_hist;
    logic signed [AVG_W-1:0] r_avg_i, r_avg_q;
    logic                    r_flag;
    logic [COUNT_W-1:0]      r_count;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    // per-item working registers
    logic [PHASE_W-1:0]      r_delta;
    logic [SYM_W-1:0]        r_sym;
    logic signed [AVG_W-1:0] r_cos, r_sin;

    // result slot
    logic               r_out_valid;
    logic [SYM_W-1:0]   r_out_sym;
    logic               r_out_cd;
    logic [PHASE_W-1:0] r_out_delta;
    logic [NCO_W-1:0]   r_out_nco;

    t_ctrl cw;
    logic  in_acc, cfg_wr, out_free;

    assign cw       = ucode(r_step);
    assign cfg_wr   = i_cfg.valid && i_cfg.ready;
    assign in_acc   = i_sym.valid && i_sym.ready;
    assign out_free = !r_out_valid || o_res.ready;

    // take nothing while reset is held
    assign i_cfg.ready = i_rst_n;
    assign i_sym.ready = i_rst_n && (cw.cond == C_IN);

    // decode the incoming phase
    logic [PHASE_W-1:0]        d, ang, d_q, d_b;
    logic [SYM_W-1:0]          s_raw, s_dec;
    logic signed [COUNT_W+1:0] c_sum;
    logic [COUNT_W-1:0]        c_new;

    always_comb begin
        d     = i_sym.symbol_phase - r_prev;
        d_q   = d + 8'h20;
        d_b   = d + 8'h40;
        s_raw = r_qpsk ? d_q[7:6] : {d_b[7], 1'b0};
        s_dec = r_lsb ? SYM_W'(2'd0 - s_raw) : s_raw;
        ang   = r_qpsk ? {d[5:0], 2'b00} : {d[6:0], 1'b0};
        // correction error; the half-turn ambiguity counts as none
        if (ang == 8'h80) begin
            c_sum = signed'({2'b00, r_count});
        end else begin
            c_sum = signed'({2'b00, r_count}) + (COUNT_W+2)'(signed'(ang));
        end
        if (c_sum < 0) begin
            c_new = '0;
        end else if (c_sum[COUNT_W]) begin
            c_new = COUNT_MAX;
        end else begin
            c_new = c_sum[COUNT_W-1:0];
        end
    end

    // shared multiplier
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;

    always_comb begin
        case (cw.a_sel)
            A_TRIG:  op_a = OPA_W'(cw.use_sin ? r_sin : r_cos);
            A_AVGI:  op_a = OPA_W'(r_avg_i);
            A_AVGQ:  op_a = OPA_W'(r_avg_q);
            A_CNT:   op_a = signed'({1'b0, r_count});
            default: op_a = '0;
        endcase
        case (cw.b_sel)
            B_KNEW:  op_b = K_NEW;
            B_KOLD:  op_b = K_OLD;
            B_AVGI:  op_b = OPB_W'(r_avg_i);
            B_AVGQ:  op_b = OPB_W'(r_avg_q);
            B_SCLO:  op_b = signed'({1'b0, r_scale[15:0]});
            B_SCHI:  op_b = signed'({1'b0, r_scale[31:16]});
            default: op_b = '0;
        endcase
        prod = op_a * op_b;
    end

    // accumulate
    always_comb begin
        case (cw.acc_op)
            ACC_HOLD:  n_acc = r_acc;
            ACC_LOAD:  n_acc = ACC_W'(prod);
            ACC_LDRND: n_acc = ACC_W'(prod) + K_ROUND;
            ACC_ADD:   n_acc = r_acc + ACC_W'(prod);
            ACC_SHADD: n_acc = (r_acc >>> 16) + ACC_W'(prod);
            default:   n_acc = r_acc;
        endcase
    end

    // level compare: P*200 against level*(1 or 2) * 2^30
    logic [31:0] pwr;
    logic [40:0] lhs, rhs;
    logic        special;

    always_comb begin
        pwr     = r_acc[31:0];
        lhs     = {2'b00, pwr, 7'b0} + {3'b000, pwr, 6'b0} + {6'b0, pwr, 3'b0};
        rhs     = r_flag ? {1'b0, r_level, 30'b0} : {r_level, 31'b0};
        special = (r_hist == HIST_PREAMBLE) || (r_hist == HIST_POSTAMBLE);
    end

    // step counter
    always_comb begin
        case (cw.cond)
            C_NEXT:  n_step = r_step + 4'd1;
            C_IN:    n_step = in_acc ? r_step + 4'd1 : r_step;
            C_OUT:   n_step = out_free ? cw.target : r_step;
            default: n_step = STEP_FIRST;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_FIRST;
            r_qpsk      <= 1'b0;
            r_lsb       <= 1'b0;
            r_afc_en    <= 1'b1;
            r_level     <= '0;
            r_scale     <= STEP_SCALE_RST;
            r_prev      <= '0;
            r_hist      <= '0;
            r_avg_i     <= '0;
            r_avg_q     <= '0;
            r_flag      <= 1'b0;
            r_count     <= TUNE_FREQ_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;

            // take an item: remember phase, extend history, correct count if locked and AFC on
            if (in_acc) begin
                r_prev <= i_sym.symbol_phase;
                r_hist <= {r_hist[HIST_W-3:0], s_dec};
                if (r_flag && r_afc_en) begin
                    r_count <= c_new;
                end
            end

            if (cw.wr_avg_i) begin
                r_avg_i <= r_acc[30:15];
            end

            // preamble forces lock, postamble clears, else store average
            if (cw.wr_avg_q) begin
                if (r_hist == HIST_PREAMBLE) begin
                    r_flag  <= 1'b1;
                    r_avg_i <= AVG_FULL;
                    r_avg_q <= '0;
                end else if (r_hist == HIST_POSTAMBLE) begin
                    r_flag  <= 1'b0;
                    r_avg_i <= '0;
                    r_avg_q <= '0;
                end else begin
                    r_avg_q <= r_acc[30:15];
                end
            end

            if (cw.chk_level && !special && (r_level != '0)) begin
                r_flag <= (lhs > rhs);
            end

            // hold the result until taken
            if (cw.emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            // configuration writes
            if (cfg_wr) begin
                case (i_cfg.index)
                    REG_QPSK_MODE:      r_qpsk   <= i_cfg.data[0];
                    REG_LOWER_SIDEBAND: r_lsb    <= i_cfg.data[0];
                    REG_AFC_ENABLE:     r_afc_en <= i_cfg.data[0];
                    REG_DETECT_LEVEL:   r_level  <= i_cfg.data[LEVEL_W-1:0];
                    REG_TUNE_FREQ:      r_count  <= i_cfg.data[COUNT_W-1:0];
                    REG_STEP_SCALE:     r_scale  <= i_cfg.data[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (in_acc) begin
            r_delta <= d;
            r_sym   <= s_dec;
            r_cos   <= rom_sin(ang + 8'h40);
            r_sin   <= rom_sin(ang);
        end
        if (cw.emit && out_free) begin
            r_out_sym   <= r_sym;
            r_out_cd    <= r_flag;
            r_out_delta <= r_delta;
            r_out_nco   <= r_acc[31:16];
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.symbol         = r_out_sym;
    assign o_res.carrier_detect = r_out_cd;
    assign o_res.phase_delta    = r_out_delta;
    assign o_res.nco_step       = r_out_nco;

endmodule

`default_nettype wire
